FILE: sv/alist_pkg.sv
// Shared types, constants and codes for the array list engine.
package alist_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOP,
    S_CMP,
    S_WR,
    S_PUT,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic [7:0]         position;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_index;
    logic [7:0] length;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;
    logic    rd;
    logic    cmp;
    logic    mv;
    logic    put;
    logic    dec;
    logic    set_st;
    status_e st;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       bad_pos;
    logic       more;
    logic       match;
  } dp_stat_t;

endpackage

FILE: sv/alist_dp.sv
// Datapath of the array list engine: element store, fill count, walk index, result fields.
module alist_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alist_pkg::item_t   item_i,
  input  alist_pkg::dp_cmd_t cmd_i,
  output alist_pkg::dp_stat_t stat_o,
  output alist_pkg::result_t result_o
);

  localparam int AddrW = alist_pkg::ADDR_W;
  localparam int CntW  = alist_pkg::CNT_W;
  localparam int CmpW  = alist_pkg::CMP_W;
  localparam int Cap   = alist_pkg::CAPACITY;

  logic [31:0]     mem_q [Cap];
  logic [31:0]     rd_data_q;
  logic [1:0]      op_q;
  logic [31:0]     value_q;
  logic [7:0]      pos_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] count_q;
  logic [6:0]      found_q;
  alist_pkg::status_e st_q;

  logic [CntW-1:0]  idx_p1;
  logic [CntW-1:0]  idx_m1;
  logic [CmpW-1:0]  pos_x;
  logic [CmpW-1:0]  cnt_x;
  logic [CntW-1:0]  rd_idx;
  logic [CntW-1:0]  idx_init;
  logic             we;
  logic [31:0]      wdata;

  assign idx_p1 = idx_q + CntW'(1);
  assign idx_m1 = idx_q - CntW'(1);
  assign pos_x  = CmpW'(pos_q);
  assign cnt_x  = CmpW'(count_q);

  // Read address: find reads in place, insert reads below, delete reads above.
  always_comb begin
    unique case (op_q)
      alist_pkg::OP_INSERT: rd_idx = idx_m1;
      alist_pkg::OP_DELETE: rd_idx = idx_p1;
      default:              rd_idx = idx_q;
    endcase
  end

  always_comb begin
    unique case (item_i.op)
      alist_pkg::OP_INSERT: idx_init = count_q;
      alist_pkg::OP_DELETE: idx_init = CntW'(item_i.position);
      default:              idx_init = '0;
    endcase
  end

  always_comb begin
    stat_o.op    = op_q;
    stat_o.full  = (count_q >= CntW'(Cap));
    stat_o.match = (rd_data_q == value_q);
    unique case (op_q)
      alist_pkg::OP_INSERT: begin
        stat_o.bad_pos = (pos_x > cnt_x);
        stat_o.more    = (CmpW'(idx_q) > pos_x);
      end
      alist_pkg::OP_DELETE: begin
        stat_o.bad_pos = (pos_x >= cnt_x);
        stat_o.more    = (idx_p1 < count_q);
      end
      default: begin
        stat_o.bad_pos = 1'b0;
        stat_o.more    = (idx_q < count_q);
      end
    endcase
  end

  assign we    = cmd_i.mv | cmd_i.put;
  assign wdata = cmd_i.put ? value_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[idx_q[AddrW-1:0]] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= item_i.op;
      value_q <= item_i.value;
      pos_q   <= item_i.position;
      idx_q   <= idx_init;
      found_q <= '0;
      st_q    <= alist_pkg::ST_OK;
    end else begin
      if (cmd_i.set_st) begin
        st_q <= cmd_i.st;
      end
      if (cmd_i.cmp) begin
        if (rd_data_q == value_q) begin
          found_q <= 7'(idx_q);
        end else begin
          idx_q <= idx_p1;
        end
      end
      if (cmd_i.mv) begin
        idx_q <= (op_q == alist_pkg::OP_INSERT) ? idx_m1 : idx_p1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.put) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.dec) begin
      count_q <= count_q - CntW'(1);
    end
  end

  assign result_o.status      = st_q;
  assign result_o.found_index = found_q;
  assign result_o.length      = 8'(count_q);

endmodule

FILE: sv/alist_ctrl.sv
// Controller state machine of the array list engine.
module alist_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  alist_pkg::dp_stat_t stat_i,
  output alist_pkg::dp_cmd_t  cmd_o,
  output logic                busy,
  output logic                result_valid_o
);

  alist_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alist_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      alist_pkg::S_IDLE: begin
        if (start) state_d = alist_pkg::S_CHECK;
      end
      alist_pkg::S_CHECK: begin
        unique case (stat_i.op)
          alist_pkg::OP_FIND:   state_d = alist_pkg::S_LOOP;
          alist_pkg::OP_INSERT: state_d = (stat_i.full || stat_i.bad_pos) ?
                                          alist_pkg::S_DONE : alist_pkg::S_LOOP;
          alist_pkg::OP_DELETE: state_d = stat_i.bad_pos ?
                                          alist_pkg::S_DONE : alist_pkg::S_LOOP;
          default:              state_d = alist_pkg::S_DONE;
        endcase
      end
      alist_pkg::S_LOOP: begin
        priority if (stat_i.more) begin
          state_d = (stat_i.op == alist_pkg::OP_FIND) ? alist_pkg::S_CMP : alist_pkg::S_WR;
        end else if (stat_i.op == alist_pkg::OP_INSERT) begin
          state_d = alist_pkg::S_PUT;
        end else begin
          state_d = alist_pkg::S_DONE;
        end
      end
      alist_pkg::S_CMP:  state_d = stat_i.match ? alist_pkg::S_DONE : alist_pkg::S_LOOP;
      alist_pkg::S_WR:   state_d = alist_pkg::S_LOOP;
      alist_pkg::S_PUT:  state_d = alist_pkg::S_DONE;
      alist_pkg::S_DONE: state_d = alist_pkg::S_IDLE;
      default:           state_d = alist_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.st       = alist_pkg::ST_OK;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      alist_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      alist_pkg::S_CHECK: begin
        if (stat_i.op == alist_pkg::OP_INSERT) begin
          priority if (stat_i.full) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = alist_pkg::ST_FULL;
          end else if (stat_i.bad_pos) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = alist_pkg::ST_BAD_POS;
          end else begin
            cmd_o.set_st = 1'b0;
          end
        end else if (stat_i.op == alist_pkg::OP_DELETE && stat_i.bad_pos) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = alist_pkg::ST_BAD_POS;
        end
      end
      alist_pkg::S_LOOP: begin
        if (stat_i.more) begin
          cmd_o.rd = 1'b1;
        end else if (stat_i.op == alist_pkg::OP_FIND) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = alist_pkg::ST_NOT_FOUND;
        end else if (stat_i.op == alist_pkg::OP_DELETE) begin
          cmd_o.dec = 1'b1;
        end
      end
      alist_pkg::S_CMP:  cmd_o.cmp      = 1'b1;
      alist_pkg::S_WR:   cmd_o.mv       = 1'b1;
      alist_pkg::S_PUT:  cmd_o.put      = 1'b1;
      alist_pkg::S_DONE: result_valid_o = 1'b1;
      default:           busy           = 1'b1;
    endcase
  end

endmodule

FILE: sv/array_list_engine.sv
// Top level of the array list engine: ordered word list with find, insert and delete.
//
//  Channel  | Ports                    | Handshake
//  ---------+--------------------------+--------------------------------------------
//  item in  | item_i, start, busy      | taken at a rising edge with start high, busy low
//  result   | result_o, result_valid_o | shown for one cycle while result_valid_o is high
//
//  Each entry walked (compared by find, moved by insert or delete) is a registered
//  read of the single-port store plus a compare or write step; a rejected item or
//  the unused code skips the walk and goes straight to the result.
//  Reset clears the fill count and the controller at once; the store needs no clear.
//  busy stays high from acceptance through the result cycle; the receiver cannot stall.
module array_list_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  alist_pkg::item_t   item_i,
  output logic               result_valid_o,
  output alist_pkg::result_t result_o
);

  // Command and status groups between the controller and the datapath.
  alist_pkg::dp_cmd_t  cmd;
  alist_pkg::dp_stat_t stat;

  // Sequence the walk: check errors, then read/compare or read/move per entry, then put the new word for insert.
  alist_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Hold the store, the fill count, the walk index and the result fields.
  alist_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

endmodule

FILE: bench/tb_array_list_engine.sv
// Self-checking bench for the array list engine: random find, insert and delete items.
`timescale 1ns / 1ps

module tb_array_list_engine;

  // Watchdog span: well above the longest item, which walks 128 entries, plus the
  // longest idle burst of the driver, so a longer quiet stretch means a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  // Drain after the last result: one full-length walk with margin.
  localparam int DRAIN_CYCLES   = 300;
  localparam int MAX_REPORTS    = 10;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start  = 1'b0;
  logic               busy;
  alist_pkg::item_t   item_i = '0;
  logic               result_valid_o;
  alist_pkg::result_t result_o;

  // Shadow of the list: packed words and their count.
  logic signed [31:0] list_words [alist_pkg::CAPACITY];
  int                 list_len = 0;

  alist_pkg::item_t   queued_items    [$];
  alist_pkg::result_t pending_results [$];

  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  int gap_left     = 0;
  bit idle_en      = 1'b1;

  array_list_engine u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Apply one item to the shadow list and return the result it must produce.
  function automatic alist_pkg::result_t apply_list_op(alist_pkg::item_t it);
    alist_pkg::result_t r;
    int                 idx;
    bit                 hit;
    r.status      = alist_pkg::ST_OK;
    r.found_index = '0;
    hit           = 1'b0;
    case (alist_pkg::op_e'(it.op))
      alist_pkg::OP_FIND: begin
        r.status = alist_pkg::ST_NOT_FOUND;
        for (idx = 0; idx < list_len && !hit; idx++) begin
          if (list_words[idx] == it.value) begin
            hit           = 1'b1;
            r.status      = alist_pkg::ST_OK;
            r.found_index = 7'(idx);
          end
        end
      end
      alist_pkg::OP_INSERT: begin
        // Full outranks a bad position.
        if (list_len >= alist_pkg::CAPACITY) begin
          r.status = alist_pkg::ST_FULL;
        end else if (int'(it.position) > list_len) begin
          r.status = alist_pkg::ST_BAD_POS;
        end else begin
          for (idx = list_len; idx > int'(it.position); idx--)
            list_words[idx] = list_words[idx - 1];
          list_words[it.position[alist_pkg::ADDR_W-1:0]] = it.value;
          list_len++;
        end
      end
      alist_pkg::OP_DELETE: begin
        // Covers the empty list too.
        if (int'(it.position) >= list_len) begin
          r.status = alist_pkg::ST_BAD_POS;
        end else begin
          for (idx = int'(it.position) + 1; idx < list_len; idx++)
            list_words[idx - 1] = list_words[idx];
          list_len--;
        end
      end
      default: ;
    endcase
    r.length = 8'(list_len);
    return r;
  endfunction

  function automatic alist_pkg::item_t make_item(alist_pkg::op_e op, logic [31:0] v,
                                                 logic [7:0] p);
    alist_pkg::item_t it;
    it.op       = op;
    it.value    = v;
    it.position = p;
    return it;
  endfunction

  // Draw a value: mostly wide random words, often a tiny pool so duplicates appear, sometimes an extreme.
  function automatic logic [31:0] draw_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'($urandom_range(0, 4)) - 32'd2;
    if (r < 30) return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    return $urandom;
  endfunction

  // Build the next random item from the current shadow length; positions are
  // mostly legal so the list grows and shrinks, the rest span the whole field.
  function automatic alist_pkg::item_t pick_item(int w_ins, int w_del);
    alist_pkg::item_t it;
    int               r;
    bit               legal;
    r            = $urandom_range(0, 99);
    legal        = ($urandom_range(0, 99) < 85);
    it.value     = draw_value();
    it.position  = 8'($urandom_range(0, 255));
    if (r < 3) begin
      it.op = alist_pkg::OP_NONE;
    end else if (r < 3 + w_ins) begin
      it.op = alist_pkg::OP_INSERT;
      if (legal) it.position = 8'($urandom_range(0, list_len));
    end else if (r < 3 + w_ins + w_del) begin
      it.op = alist_pkg::OP_DELETE;
      if (legal && list_len > 0) it.position = 8'($urandom_range(0, list_len - 1));
    end else begin
      it.op = alist_pkg::OP_FIND;
      // Look up a stored word most of the time.
      if (list_len > 0 && $urandom_range(0, 99) < 65)
        it.value = list_words[$urandom_range(0, list_len - 1)];
    end
    return it;
  endfunction

  // Hold until the driver has taken the last item, so the shadow is current.
  task automatic wait_slot();
    do @(negedge clk_i); while (queued_items.size() != 0);
  endtask

  task automatic run_phase(int n, int w_ins, int w_del, bit allow_idle);
    for (int i = 0; i < n; i++) begin
      // Switch idling per stretch so some stretches run back to back.
      if (i % 40 == 0) idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      wait_slot();
      queued_items.push_back(pick_item(w_ins, w_del));
    end
  endtask

  // Driver: present the oldest queued item, hold it until taken, then idle in bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else if (start && !busy) begin
      // Item taken at this edge: predict and drop it from the queue.
      pending_results.push_back(apply_list_op(item_i));
      queued_items.delete(0);
      gap_left = (idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
      start <= 1'b0;
    end else if (!start && queued_items.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        item_i <= queued_items[0];
        start  <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string what, alist_pkg::result_t exp_r,
                                 alist_pkg::result_t got_r);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("mismatch (%s): expected status=%0d index=%0d length=%0d",
               what, exp_r.status, exp_r.found_index, exp_r.length);
      $display("  got status=%0d index=%0d length=%0d",
               got_r.status, got_r.found_index, got_r.length);
    end
  endtask

  // Monitor: each strobed result must match the oldest prediction field by field.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("no result expected", '0, result_o);
      end else begin
        if (result_o.status !== pending_results[0].status ||
            result_o.found_index !== pending_results[0].found_index ||
            result_o.length !== pending_results[0].length)
          report_mismatch("field", pending_results[0], result_o);
        pending_results.delete(0);
      end
    end
  end

  // Watchdog: end the run after too many cycles with no item and no result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty list, bad positions, extremes, duplicates, every operation.
    queued_items.push_back(make_item(alist_pkg::OP_FIND,   32'd0,         8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_DELETE, 32'd0,         8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'd9,         8'd1));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'd9,         8'd255));
    queued_items.push_back(make_item(alist_pkg::OP_NONE,   32'hffff_ffff, 8'hff));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'h8000_0000, 8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'h7fff_ffff, 8'd1));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'hffff_ffff, 8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'd0,         8'd1));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'd5,         8'd5));
    queued_items.push_back(make_item(alist_pkg::OP_INSERT, 32'd0,         8'd4));
    queued_items.push_back(make_item(alist_pkg::OP_FIND,   32'd0,         8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_FIND,   32'h7fff_ffff, 8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_FIND,   32'h8000_0000, 8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_FIND,   32'hffff_ffff, 8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_FIND,   32'd12345,     8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_DELETE, 32'd0,         8'd5));
    queued_items.push_back(make_item(alist_pkg::OP_DELETE, 32'd0,         8'd255));
    queued_items.push_back(make_item(alist_pkg::OP_DELETE, 32'd0,         8'd4));
    queued_items.push_back(make_item(alist_pkg::OP_DELETE, 32'd0,         8'd0));
    queued_items.push_back(make_item(alist_pkg::OP_DELETE, 32'd0,         8'd1));
    queued_items.push_back(make_item(alist_pkg::OP_NONE,   32'h5a5a_a5a5, 8'h55));
    queued_items.push_back(make_item(alist_pkg::OP_FIND,   32'h7fff_ffff, 8'd255));

    // Random: fill to capacity and past it, drain back down, then mix.
    run_phase(320, 65, 10, 1'b1);
    run_phase(250, 15, 60, 1'b1);
    run_phase(130, 45, 40, 1'b1);
    run_phase(150, 45, 40, 1'b0);

    while (queued_items.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/alist_pkg.sv
sv/alist_dp.sv
sv/alist_ctrl.sv
sv/array_list_engine.sv
bench/tb_array_list_engine.sv
